[rtl/core/i2csbs_pkg.sv]
// Shared types and constants for the I2C slave byte sequencer.
// Used by i2csbs_fsm and i2c_slave_byte_sequencer_unit; no dependencies.
`default_nettype none

package i2csbs_pkg;

  // Configuration register indexes
  localparam logic [1:0] CFG_SLAVE_ADDRESS = 2'd0;
  localparam logic [1:0] CFG_MAX_RX_BYTES  = 2'd1;
  localparam logic [1:0] CFG_ECHO_BYTE     = 2'd2;

  // Configuration reset values
  localparam logic [6:0] SLAVE_ADDRESS_RST = 7'd72;
  localparam logic [7:0] MAX_RX_BYTES_RST  = 8'd5;
  localparam logic [7:0] ECHO_BYTE_RST     = 8'h55;

  // Shift values and bit counts
  localparam logic [7:0] ACK_BYTE  = 8'h00;
  localparam logic [7:0] NACK_BYTE = 8'hFF;
  localparam logic [3:0] BITS_NONE = 4'd0;
  localparam logic [3:0] BITS_ACK  = 4'd1;
  localparam logic [3:0] BITS_BYTE = 4'd8;

  // One shift-unit event
  typedef struct packed {
    logic       start_seen;
    logic [7:0] shifted_in;
  } in_item_t;

  // One sequencer result
  typedef struct packed {
    logic       load_shift;
    logic [7:0] shift_value;
    logic [3:0] bits_to_clock;
    logic       sda_enable;
    logic       led_level;
    logic       transfer_done;
  } out_item_t;

  // Configuration register set
  typedef struct packed {
    logic [6:0] slave_address;
    logic [7:0] max_rx_bytes;
    logic [7:0] echo_byte;
  } cfg_regs_t;

endpackage

`default_nettype wire

[rtl/core/i2c_slave_byte_sequencer_unit.sv]
// Top level of the I2C slave byte sequencer: request channels, config registers.
// Depends on i2csbs_pkg and i2csbs_fsm.
`default_nettype none

// Byte-level sequencer of a 7-bit-address I2C slave. Each input request is one
// shift-unit event (start flag plus shifted-in byte); each produces exactly one
// result request telling what to load into the shifter, how many bits to clock,
// and the current SDA drive and LED level. Throughput is one event per clock
// while the output is not stalled: an event is captured in an input register,
// the phase logic runs in one pass, and the result lands in an output register.
// Both stages advance whenever the output register is empty or being taken.
// Configuration writes are always ready and take effect on the next event;
// index 0 is the slave address, 1 the maximum receive byte count, 2 the echo
// byte; other indexes are ignored.
module i2c_slave_byte_sequencer_unit (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  // event input
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire i2csbs_pkg::in_item_t  in_data,
  // result output
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output i2csbs_pkg::out_item_t      out_data,
  // configuration writes
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [1:0]            cfg_index,
  input  wire logic [7:0]            cfg_data
);
  import i2csbs_pkg::*;

  logic      s1_valid_r;
  in_item_t  s1_item_r;
  logic      out_valid_r;
  out_item_t out_data_r;
  cfg_regs_t cfg_r;
  out_item_t result;
  logic      advance;
  logic      step;

  // Pipeline moves when the output register is free or being taken
  assign advance   = !out_valid_r || !out_stall;
  assign step      = s1_valid_r && advance;
  assign in_stall  = s1_valid_r && !advance;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign cfg_ready = 1'b1;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.slave_address <= SLAVE_ADDRESS_RST;
      cfg_r.max_rx_bytes  <= MAX_RX_BYTES_RST;
      cfg_r.echo_byte     <= ECHO_BYTE_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_SLAVE_ADDRESS: cfg_r.slave_address <= cfg_data[6:0];
        CFG_MAX_RX_BYTES:  cfg_r.max_rx_bytes  <= cfg_data;
        CFG_ECHO_BYTE:     cfg_r.echo_byte     <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // Input register stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (advance || !s1_valid_r) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_item_r <= in_data;
    end
  end

  // Phase logic and state
  i2csbs_fsm u_fsm (
    .clk    (clk),
    .rst_n  (rst_n),
    .step   (step),
    .item   (s1_item_r),
    .cfg    (cfg_r),
    .result (result)
  );

  // Result register stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      out_data_r <= result;
    end
  end

endmodule

`default_nettype wire

[rtl/core/i2csbs_fsm.sv]
// Bus phase state machine of the I2C slave byte sequencer.
// Holds phase, byte count, LED and SDA drive; depends on i2csbs_pkg.
`default_nettype none

module i2csbs_fsm (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   step,
  input  wire i2csbs_pkg::in_item_t   item,
  input  wire i2csbs_pkg::cfg_regs_t  cfg,
  output i2csbs_pkg::out_item_t       result
);
  import i2csbs_pkg::*;

  typedef enum logic [2:0] {
    PH_IDLE     = 3'd0,
    PH_RX_ADDR  = 3'd1,
    PH_CHK_ADDR = 3'd2,
    PH_RX_DATA  = 3'd3,
    PH_CHK_DATA = 3'd4,
    PH_TX_DATA  = 3'd5,
    PH_RX_ACK   = 3'd6,
    PH_CHK_ACK  = 3'd7
  } phase_t;

  phase_t     phase_r, phase_nxt, phase_cur;
  logic [7:0] byte_count_r, byte_count_nxt;
  logic       led_r, led_nxt;
  logic       sda_r, sda_nxt;
  logic       done;
  logic       load;
  logic [7:0] val;
  logic [3:0] bits;
  logic [8:0] count_plus2;

  assign count_plus2 = {1'b0, byte_count_r} + 9'd2;

  // Decide the response to the current event
  always_comb begin
    phase_cur      = item.start_seen ? PH_RX_ADDR : phase_r;
    led_nxt        = item.start_seen ? 1'b1 : led_r;
    phase_nxt      = phase_cur;
    byte_count_nxt = byte_count_r;
    sda_nxt        = sda_r;
    load           = 1'b0;
    val            = ACK_BYTE;
    bits           = BITS_NONE;
    done           = 1'b0;
    unique case (phase_cur)
      PH_RX_ADDR: begin
        bits      = BITS_BYTE;
        phase_nxt = PH_CHK_ADDR;
      end
      PH_CHK_ADDR: begin
        load = 1'b1;
        if (item.shifted_in[7:1] == cfg.slave_address) begin
          sda_nxt   = 1'b1;
          val       = ACK_BYTE;
          bits      = BITS_ACK;
          led_nxt   = 1'b0;
          phase_nxt = item.shifted_in[0] ? PH_TX_DATA : PH_RX_DATA;
        end else begin
          // address mismatch: release the bus and go idle
          val            = NACK_BYTE;
          led_nxt        = 1'b1;
          sda_nxt        = 1'b0;
          byte_count_nxt = '0;
          phase_nxt      = PH_IDLE;
          done           = 1'b1;
        end
      end
      PH_RX_DATA: begin
        sda_nxt   = 1'b0;
        bits      = BITS_BYTE;
        phase_nxt = PH_CHK_DATA;
      end
      PH_CHK_DATA: begin
        load = 1'b1;
        if (count_plus2 <= {1'b0, cfg.max_rx_bytes}) begin
          sda_nxt        = 1'b1;
          val            = ACK_BYTE;
          bits           = BITS_ACK;
          byte_count_nxt = byte_count_r + 8'd1;
          phase_nxt      = PH_RX_DATA;
        end else begin
          // final byte of the write gets a NACK
          val            = NACK_BYTE;
          sda_nxt        = 1'b0;
          byte_count_nxt = '0;
          phase_nxt      = PH_IDLE;
          done           = 1'b1;
        end
      end
      PH_TX_DATA: begin
        sda_nxt   = 1'b1;
        load      = 1'b1;
        val       = cfg.echo_byte;
        bits      = BITS_BYTE;
        phase_nxt = PH_RX_ACK;
      end
      PH_RX_ACK: begin
        sda_nxt   = 1'b0;
        bits      = BITS_ACK;
        phase_nxt = PH_CHK_ACK;
      end
      PH_CHK_ACK: begin
        if (item.shifted_in[0]) begin
          // master NACK ends the read
          sda_nxt        = 1'b0;
          byte_count_nxt = '0;
          phase_nxt      = PH_IDLE;
          done           = 1'b1;
        end else begin
          led_nxt   = 1'b0;
          sda_nxt   = 1'b1;
          load      = 1'b1;
          val       = cfg.echo_byte;
          bits      = BITS_BYTE;
          phase_nxt = PH_RX_ACK;
        end
      end
      default: begin
        // idle without start: nothing changes
      end
    endcase

    result.load_shift    = load;
    result.shift_value   = val;
    result.bits_to_clock = bits;
    result.sda_enable    = sda_nxt;
    result.led_level     = led_nxt;
    result.transfer_done = done;
  end

  // State update on each processed event
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= PH_IDLE;
      byte_count_r <= '0;
      led_r        <= 1'b0;
      sda_r        <= 1'b0;
    end else if (step) begin
      phase_r      <= phase_nxt;
      byte_count_r <= byte_count_nxt;
      led_r        <= led_nxt;
      sda_r        <= sda_nxt;
    end
  end

endmodule

`default_nettype wire

[sim/tb.sv]
// Self-checking bench for i2c_slave_byte_sequencer_unit: random bus event streams
// against a cycle-free model of the sequencer. Depends on i2csbs_pkg and the RTL.
`timescale 1ns / 100ps

module tb;
  import i2csbs_pkg::*;

  localparam int         CYCLE_LIMIT      = 400000;
  localparam int         LONG_HOLD        = 250;
  localparam int         HOLD_AT_FIRST    = 200;
  localparam int         HOLD_AT_SECOND   = 1000;
  localparam int         DRAIN_GAP        = 6;
  localparam logic [1:0] CFG_UNUSED_INDEX = 2'd3;

  typedef enum logic [2:0] {
    PH_IDLE, PH_RX_ADDR, PH_CHK_ADDR, PH_RX_DATA,
    PH_CHK_DATA, PH_TX_DATA, PH_RX_ACK, PH_CHK_ACK
  } seq_phase_t;

  typedef enum logic [1:0] {RX_FREE, RX_COIN, RX_SPARSE, RX_PERIODIC} rx_mode_t;

  logic       clk       = 1'b0;
  logic       rst_n     = 1'b0;
  logic       in_valid  = 1'b0;
  logic       in_stall;
  in_item_t   in_data   = '0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  out_item_t  out_data;
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  logic [1:0] cfg_index = '0;
  logic [7:0] cfg_data  = '0;

  // Sequencer model: configuration and state
  logic [6:0] reg_addr   = SLAVE_ADDRESS_RST;
  logic [7:0] reg_max_rx = MAX_RX_BYTES_RST;
  logic [7:0] reg_echo   = ECHO_BYTE_RST;
  seq_phase_t seq_phase  = PH_IDLE;
  logic [7:0] seq_count  = '0;
  logic       seq_led    = 1'b0;
  logic       seq_sda    = 1'b0;

  in_item_t  pending_events[$];
  out_item_t expected_results[$];
  out_item_t want;

  int errors        = 0;
  int results_seen  = 0;
  int cycles        = 0;
  int gap_left      = 0;
  int burst_left    = 0;
  int hold_left     = 0;
  int mode_left     = 0;
  int periodic_cnt  = 0;
  rx_mode_t rx_mode = RX_FREE;

  i2c_slave_byte_sequencer_unit i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Advance the sequencer model by one bus event and return its result
  function automatic out_item_t next_sequencer_result(in_item_t ev);
    out_item_t r;
    r = '0;
    if (ev.start_seen) begin
      seq_led   = 1'b1;
      seq_phase = PH_RX_ADDR;
    end
    case (seq_phase)
      PH_RX_ADDR: begin
        r.bits_to_clock = BITS_BYTE;
        seq_phase       = PH_CHK_ADDR;
      end
      PH_CHK_ADDR: begin
        seq_sda      = 1'b1;
        r.load_shift = 1'b1;
        if (ev.shifted_in[7:1] == reg_addr) begin
          r.shift_value   = ACK_BYTE;
          r.bits_to_clock = BITS_ACK;
          seq_led         = 1'b0;
          seq_phase       = ev.shifted_in[0] ? PH_TX_DATA : PH_RX_DATA;
        end else begin
          // wrong address: reject, light the LED, back to idle
          r.shift_value   = NACK_BYTE;
          seq_led         = 1'b1;
          seq_sda         = 1'b0;
          seq_count       = '0;
          seq_phase       = PH_IDLE;
          r.transfer_done = 1'b1;
        end
      end
      PH_RX_DATA: begin
        seq_sda         = 1'b0;
        r.bits_to_clock = BITS_BYTE;
        seq_phase       = PH_CHK_DATA;
      end
      PH_CHK_DATA: begin
        seq_sda      = 1'b1;
        r.load_shift = 1'b1;
        if ({1'b0, seq_count} + 9'd2 <= {1'b0, reg_max_rx}) begin
          r.shift_value   = ACK_BYTE;
          r.bits_to_clock = BITS_ACK;
          seq_count       = seq_count + 8'd1;
          seq_phase       = PH_RX_DATA;
        end else begin
          // last byte of the write gets NACK
          r.shift_value   = NACK_BYTE;
          seq_sda         = 1'b0;
          seq_count       = '0;
          seq_phase       = PH_IDLE;
          r.transfer_done = 1'b1;
        end
      end
      PH_TX_DATA: begin
        seq_sda         = 1'b1;
        r.load_shift    = 1'b1;
        r.shift_value   = reg_echo;
        r.bits_to_clock = BITS_BYTE;
        seq_phase       = PH_RX_ACK;
      end
      PH_RX_ACK: begin
        seq_sda         = 1'b0;
        r.bits_to_clock = BITS_ACK;
        seq_phase       = PH_CHK_ACK;
      end
      PH_CHK_ACK: begin
        if (ev.shifted_in[0]) begin
          // master NACK ends the read
          seq_sda         = 1'b0;
          seq_count       = '0;
          seq_phase       = PH_IDLE;
          r.transfer_done = 1'b1;
        end else begin
          seq_led         = 1'b0;
          seq_sda         = 1'b1;
          r.load_shift    = 1'b1;
          r.shift_value   = reg_echo;
          r.bits_to_clock = BITS_BYTE;
          seq_phase       = PH_RX_ACK;
        end
      end
      default: ;
    endcase
    r.sda_enable = seq_sda;
    r.led_level  = seq_led;
    return r;
  endfunction

  task automatic check_field(input string name, input logic [7:0] exp_val,
                             input logic [7:0] act_val);
    if (exp_val !== act_val) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, exp_val, act_val);
      errors++;
    end
  endtask

  // Driver: bursts of requests with random gaps, payload held while stalled
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid   <= 1'b0;
      gap_left   = 0;
      burst_left = 0;
    end else begin
      if (in_valid && !in_stall)
        expected_results.push_back(next_sequencer_result(in_data));
      if (!(in_valid && in_stall)) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (pending_events.size() > 0) begin
          in_data  <= pending_events.pop_front();
          in_valid <= 1'b1;
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(1, 48);
            gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 10);
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: check each taken result, drive the stall pattern
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_results.size() == 0) begin
          $error("result with nothing expected: %p", out_data);
          errors++;
        end else begin
          want = expected_results.pop_front();
          check_field("load_shift", 8'(want.load_shift), 8'(out_data.load_shift));
          check_field("shift_value", want.shift_value, out_data.shift_value);
          check_field("bits_to_clock", 8'(want.bits_to_clock),
                      8'(out_data.bits_to_clock));
          check_field("sda_enable", 8'(want.sda_enable), 8'(out_data.sda_enable));
          check_field("led_level", 8'(want.led_level), 8'(out_data.led_level));
          check_field("transfer_done", 8'(want.transfer_done),
                      8'(out_data.transfer_done));
        end
        results_seen++;
        if (results_seen == HOLD_AT_FIRST || results_seen == HOLD_AT_SECOND)
          hold_left = LONG_HOLD;
      end
      // long hold-off lets the pipe fill and back up into the input
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        if (mode_left == 0) begin
          rx_mode   = rx_mode_t'($urandom_range(0, 3));
          mode_left = $urandom_range(20, 120);
        end
        mode_left--;
        periodic_cnt++;
        case (rx_mode)
          RX_FREE:     out_stall <= 1'b0;
          RX_COIN:     out_stall <= 1'($urandom_range(0, 1));
          RX_SPARSE:   out_stall <= ($urandom_range(0, 7) == 0);
          RX_PERIODIC: out_stall <= (periodic_cnt % 3 == 0);
          default:     out_stall <= 1'b0;
        endcase
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  task automatic push_ev(input logic s, input logic [7:0] v);
    in_item_t ev;
    ev.start_seen = s;
    ev.shifted_in = v;
    pending_events.push_back(ev);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [7:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      CFG_SLAVE_ADDRESS: reg_addr   = val[6:0];
      CFG_MAX_RX_BYTES:  reg_max_rx = val;
      CFG_ECHO_BYTE:     reg_echo   = val;
      default: ;
    endcase
  endtask

  // Wait until every request has been taken and every result checked
  task automatic wait_drained();
    do @(negedge clk);
    while (pending_events.size() != 0 || in_valid || expected_results.size() != 0);
    repeat (DRAIN_GAP) @(negedge clk);
  endtask

  // Write transfer; a broken one is cut short by the next start
  task automatic gen_write(input bit full);
    int eff;
    int pairs;
    bit broken;
    eff    = (reg_max_rx == 0) ? 1 : int'(reg_max_rx);
    pairs  = (full || eff <= 16) ? eff : $urandom_range(1, 16);
    broken = ($urandom_range(0, 9) == 0);
    if (broken) pairs = $urandom_range(0, pairs);
    push_ev(1'b1, 8'($urandom));
    push_ev(1'b0, {reg_addr, 1'b0});
    for (int i = 0; i < pairs; i++) begin
      push_ev(1'b0, 8'($urandom));
      push_ev(1'b0, 8'($urandom));
    end
    if (broken && $urandom_range(0, 1)) push_ev(1'b0, 8'($urandom));
  endtask

  // Read transfer: echo bytes acked by the master, then a NACK unless broken
  task automatic gen_read();
    int acks;
    bit broken;
    acks   = $urandom_range(0, 6);
    broken = ($urandom_range(0, 9) == 0);
    push_ev(1'b1, 8'($urandom));
    push_ev(1'b0, {reg_addr, 1'b1});
    push_ev(1'b0, 8'($urandom));
    for (int i = 0; i < acks; i++) begin
      push_ev(1'b0, 8'($urandom));
      push_ev(1'b0, {7'($urandom), 1'b0});
    end
    if (!broken) begin
      push_ev(1'b0, 8'($urandom));
      push_ev(1'b0, {7'($urandom), 1'b1});
    end
  endtask

  task automatic gen_bad_address();
    logic [6:0] a;
    do a = 7'($urandom); while (a == reg_addr);
    push_ev(1'b1, 8'($urandom));
    push_ev(1'b0, {a, 1'($urandom)});
  endtask

  task automatic gen_noise();
    int n;
    n = $urandom_range(1, 4);
    for (int i = 0; i < n; i++)
      push_ev(($urandom_range(0, 3) == 0), 8'($urandom));
  endtask

  task automatic gen_phase(input int n_items);
    bit long_write;
    int pick;
    // with a large byte limit, one write runs all the way to the NACK
    long_write = (reg_max_rx > 16);
    while (pending_events.size() < n_items) begin
      pick = $urandom_range(0, 99);
      if (pick < 40) begin
        gen_write(long_write);
        long_write = 1'b0;
      end else if (pick < 75) begin
        gen_read();
      end else if (pick < 87) begin
        gen_bad_address();
      end else begin
        gen_noise();
      end
    end
  endtask

  task automatic run_phase(input logic [7:0] addr_byte, input logic [7:0] max_rx,
                           input logic [7:0] echo, input int n_items);
    write_reg(CFG_SLAVE_ADDRESS, addr_byte);
    write_reg(CFG_MAX_RX_BYTES, max_rx);
    write_reg(CFG_ECHO_BYTE, echo);
    @(negedge clk);
    gen_phase(n_items);
    wait_drained();
  endtask

  // Stimulus sequence
  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Reset config: idle events, write ack, repeated start, read, bad addresses
    push_ev(1'b0, 8'h00);
    push_ev(1'b0, 8'hFF);
    push_ev(1'b1, 8'hFF);
    push_ev(1'b0, 8'h90);
    push_ev(1'b0, 8'hAB);
    push_ev(1'b0, 8'h00);
    push_ev(1'b1, 8'h00);
    push_ev(1'b0, 8'h91);
    push_ev(1'b0, 8'h00);
    push_ev(1'b0, 8'hFF);
    push_ev(1'b0, 8'hFE);
    push_ev(1'b0, 8'h00);
    push_ev(1'b0, 8'h01);
    push_ev(1'b1, 8'h5A);
    push_ev(1'b0, 8'hFF);
    push_ev(1'b1, 8'h00);
    push_ev(1'b0, 8'h00);
    wait_drained();

    // Two-byte limit: one ack, then NACK on the second byte
    write_reg(CFG_MAX_RX_BYTES, 8'd2);
    @(negedge clk);
    push_ev(1'b1, 8'h00);
    push_ev(1'b0, 8'h90);
    push_ev(1'b0, 8'hFF);
    push_ev(1'b0, 8'h00);
    push_ev(1'b0, 8'h7E);
    push_ev(1'b0, 8'h81);
    wait_drained();

    // Random phases across register settings
    run_phase(8'd72, 8'd1, 8'h00, 320);
    run_phase(8'd127, 8'd255, 8'hFF, 320);
    write_reg(CFG_UNUSED_INDEX, 8'($urandom));
    run_phase(8'd0, 8'd5, 8'h55, 320);
    run_phase({1'b0, 7'($urandom)}, 8'd0, 8'($urandom), 300);
    run_phase({1'b1, 7'($urandom)}, 8'($urandom_range(1, 16)), 8'($urandom), 320);
    run_phase(8'($urandom), 8'($urandom_range(2, 8)), 8'($urandom), 320);

    repeat (8) @(posedge clk);
    if (errors == 0 && expected_results.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
